>>> src/ckb_pkg.sv
// Shared constants, register codes and types for the colour-key sprite blitter.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package ckb_pkg;

   // Screen and image geometry
   localparam int SCREEN_WIDTH   = 320;
   localparam int SCREEN_HEIGHT  = 240;
   localparam int MAX_IMAGE_SIDE = 256;
   localparam int ROW_BYTES      = 2 * SCREEN_WIDTH;

   // Field widths
   localparam int COUNT_W     = $clog2(MAX_IMAGE_SIDE);
   localparam int SIDE_W      = COUNT_W + 1;
   localparam int POS_W       = 11;
   localparam int HOT_W       = 8;
   localparam int COLOUR_W    = 8;
   localparam int KEY_W       = 9;
   localparam int ADDR_W      = 18;
   localparam int COORD_W     = POS_W + 1;
   localparam int ADDR_CALC_W = 2 * COORD_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_POS_X        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_Y        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HOT_X        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HOT_Y        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSPARENT  = 3'd6;

   // Register file contents
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [HOT_W-1:0]         hot_x;
      logic [HOT_W-1:0]         hot_y;
      logic [SIDE_W-1:0]        image_width;
      logic [SIDE_W-1:0]        image_height;
      logic signed [KEY_W-1:0]  transparent_colour;
   } cfg_type;

   // One source pixel with its place in the image
   typedef struct packed {
      logic                valid;
      logic [COLOUR_W-1:0] colour;
      logic [COUNT_W-1:0]  col;
      logic [COUNT_W-1:0]  row;
   } pixel_type;

endpackage

>>> src/ckb_config.sv
// Configuration register file for the blitter.
// Depends on ckb_pkg for register codes and the cfg_type struct.
module ckb_config (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [ckb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ckb_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output ckb_pkg::cfg_type                 cfg
);

   ckb_pkg::cfg_type cfg_ff;

   // Decode writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x              <= '0;
         cfg_ff.pos_y              <= '0;
         cfg_ff.hot_x              <= '0;
         cfg_ff.hot_y              <= '0;
         cfg_ff.image_width        <= ckb_pkg::SIDE_W'(1);
         cfg_ff.image_height       <= ckb_pkg::SIDE_W'(1);
         cfg_ff.transparent_colour <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ckb_pkg::REG_POS_X:
               cfg_ff.pos_x <= csr_write_data[ckb_pkg::POS_W-1:0];
            ckb_pkg::REG_POS_Y:
               cfg_ff.pos_y <= csr_write_data[ckb_pkg::POS_W-1:0];
            ckb_pkg::REG_HOT_X:
               cfg_ff.hot_x <= csr_write_data[ckb_pkg::HOT_W-1:0];
            ckb_pkg::REG_HOT_Y:
               cfg_ff.hot_y <= csr_write_data[ckb_pkg::HOT_W-1:0];
            ckb_pkg::REG_IMAGE_WIDTH:
               cfg_ff.image_width <= csr_write_data[ckb_pkg::SIDE_W-1:0];
            ckb_pkg::REG_IMAGE_HEIGHT:
               cfg_ff.image_height <= csr_write_data[ckb_pkg::SIDE_W-1:0];
            ckb_pkg::REG_TRANSPARENT:
               cfg_ff.transparent_colour <= csr_write_data[ckb_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/ckb_position.sv
// Input stage: takes source pixels, tracks column/row and registers each beat.
// Depends on ckb_pkg for widths and the pixel_type struct.
module ckb_position (
   input  logic                           clock,
   input  logic                           reset,
   input  ckb_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ckb_pkg::COLOUR_W-1:0]   req_src_colour,
   input  logic                           advance,
   output ckb_pkg::pixel_type             pixel
);

   logic                           valid_ff;
   logic [ckb_pkg::COLOUR_W-1:0]   colour_ff;
   logic [ckb_pkg::COUNT_W-1:0]    col_ff, row_ff;
   logic [ckb_pkg::COUNT_W-1:0]    pix_col_ff, pix_row_ff;
   logic [ckb_pkg::COUNT_W-1:0]    col_in, row_in;
   logic                           accept;
   logic                           col_last, row_last, row_step;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // Raster counters: an out-of-range size never matches, so it wraps at full count
   always_comb begin
      col_last = {1'b0, col_ff} == (cfg.image_width - ckb_pkg::SIDE_W'(1));
      row_last = {1'b0, row_ff} == (cfg.image_height - ckb_pkg::SIDE_W'(1));
      row_step = col_last || (col_ff == '1);
      col_in   = col_last ? '0 : col_ff + ckb_pkg::COUNT_W'(1);
      if (row_step) begin
         row_in = row_last ? '0 : row_ff + ckb_pkg::COUNT_W'(1);
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            valid_ff <= 1'b1;
         end else if (advance) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Pixel payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         colour_ff  <= req_src_colour;
         pix_col_ff <= col_ff;
         pix_row_ff <= row_ff;
      end
   end

   assign pixel.valid  = valid_ff;
   assign pixel.colour = colour_ff;
   assign pixel.col    = pix_col_ff;
   assign pixel.row    = pix_row_ff;

endmodule

>>> src/ckb_clip.sv
// Clip and colour-key test, address generation and the result register.
// Depends on ckb_pkg for geometry constants and the cfg/pixel structs.
module ckb_clip (
   input  logic                           clock,
   input  logic                           reset,
   input  ckb_pkg::cfg_type               cfg,
   input  ckb_pkg::pixel_type             pixel,
   output logic                           advance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ckb_pkg::ADDR_W-1:0]     rsp_write_address,
   output logic [ckb_pkg::COLOUR_W-1:0]   rsp_pixel_colour
);

   logic signed [ckb_pkg::COORD_W-1:0]  sx, sy;
   logic [ckb_pkg::ADDR_CALC_W-1:0]     addr_full;
   logic                                on_screen, opaque, draw, slot_free;
   logic                                rsp_valid_ff;
   logic [ckb_pkg::ADDR_W-1:0]          addr_ff;
   logic [ckb_pkg::COLOUR_W-1:0]        colour_ff;

   // Screen position of the pixel: pos - hot + counter
   always_comb begin
      sx = ckb_pkg::COORD_W'(cfg.pos_x)
         - $signed({{(ckb_pkg::COORD_W - ckb_pkg::HOT_W){1'b0}}, cfg.hot_x})
         + $signed({{(ckb_pkg::COORD_W - ckb_pkg::COUNT_W){1'b0}}, pixel.col});
      sy = ckb_pkg::COORD_W'(cfg.pos_y)
         - $signed({{(ckb_pkg::COORD_W - ckb_pkg::HOT_W){1'b0}}, cfg.hot_y})
         + $signed({{(ckb_pkg::COORD_W - ckb_pkg::COUNT_W){1'b0}}, pixel.row});
      on_screen = !sx[ckb_pkg::COORD_W-1]
               && (sx < $signed(ckb_pkg::COORD_W'(ckb_pkg::SCREEN_WIDTH)))
               && !sy[ckb_pkg::COORD_W-1]
               && (sy < $signed(ckb_pkg::COORD_W'(ckb_pkg::SCREEN_HEIGHT)));
      // a key outside 0..255 never matches
      opaque    = $signed({1'b0, pixel.colour}) != cfg.transparent_colour;
      draw      = pixel.valid && on_screen && opaque;
      addr_full = ckb_pkg::ADDR_CALC_W'(ckb_pkg::ROW_BYTES)
                  * ckb_pkg::ADDR_CALC_W'($unsigned(sy))
                + (ckb_pkg::ADDR_CALC_W'($unsigned(sx)) << 1);
   end

   // Dropped pixels leave at once; drawn ones wait for a free result slot
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = pixel.valid && (!draw || slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (draw && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (draw && slot_free) begin
         addr_ff   <= addr_full[ckb_pkg::ADDR_W-1:0];
         colour_ff <= pixel.colour;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_pixel_colour  = colour_ff;

endmodule

>>> src/clipped_colour_key_blit.sv
// Colour-key sprite blitter with screen clipping: top level.
// Depends on ckb_pkg, ckb_config, ckb_position and ckb_clip.
//
// Program the sprite placement, hot spot, image size and transparent colour
// through the csr_ port while the block is idle, then stream the source
// image one pixel per req_ beat in raster order. Each pixel that lands on the
// 320x240 screen and differs from the transparent colour (-1 disables the
// key) gives one rsp_ beat with the byte address 640*row + 2*col of its
// doubled pair; other pixels give no beat but still advance the column and
// row counters, which wrap after the last pixel of the image. The block takes
// one pixel every clock while rsp_ready is high: a pixel is held in the input
// register, and a drawn one then passes to the result register, which drives
// its rsp_ beat.
module clipped_colour_key_blit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [ckb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ckb_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ckb_pkg::COLOUR_W-1:0]   req_src_colour,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ckb_pkg::ADDR_W-1:0]     rsp_write_address,
   output logic [ckb_pkg::COLOUR_W-1:0]   rsp_pixel_colour
);

   ckb_pkg::cfg_type   cfg;
   ckb_pkg::pixel_type pixel;
   logic               advance;

   // Register file
   ckb_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Input register and raster counters
   ckb_position u_position (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_src_colour (req_src_colour),
      .advance        (advance),
      .pixel          (pixel)
   );

   // Clip, key test and result register
   ckb_clip u_clip (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .pixel             (pixel),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_colour  (rsp_pixel_colour)
   );

endmodule

>>> tb/ckb_blit_checker.sv
// Scoreboard for the colour-key sprite blitter: tracks register writes,
// predicts frame-buffer writes per accepted pixel and checks every rsp_ beat.
// Depends on ckb_pkg for widths, register codes and the register file type.
module ckb_blit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ckb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ckb_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [ckb_pkg::COLOUR_W-1:0]    req_src_colour,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [ckb_pkg::ADDR_W-1:0]      rsp_write_address,
   input  logic [ckb_pkg::COLOUR_W-1:0]    rsp_pixel_colour,
   output int                              mismatch_count,
   output int                              pending_writes
);
   import ckb_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [COLOUR_W-1:0] colour;
   } fb_write_type;

   cfg_type             sprite;
   logic [COUNT_W-1:0]  column_count;
   logic [COUNT_W-1:0]  row_count;
   fb_write_type        expected_writes[$];
   int                  errors = 0;

   // Screen position of the current pixel, clip test and colour key
   function automatic logic predict_pixel_write(input logic [COLOUR_W-1:0] colour,
                                                output fb_write_type write);
      int x;
      int y;
      int key;
      int c;
      x   = $signed(sprite.pos_x) - int'(sprite.hot_x) + int'(column_count);
      y   = $signed(sprite.pos_y) - int'(sprite.hot_y) + int'(row_count);
      key = $signed(sprite.transparent_colour);
      c   = int'(colour);
      write.address = ADDR_W'(ROW_BYTES * y + 2 * x);
      write.colour  = colour;
      return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT && c != key;
   endfunction

   function automatic logic [COUNT_W-1:0] next_row();
      logic [SIDE_W-1:0] last_row;
      last_row = sprite.image_height - 1'b1;
      return ({1'b0, row_count} == last_row) ? '0 : row_count + 1'b1;
   endfunction

   // Raster counters: a side of 0 or above 256 never matches, so it wraps at 256
   function automatic void step_raster();
      logic [SIDE_W-1:0] last_col;
      last_col = sprite.image_width - 1'b1;
      if ({1'b0, column_count} == last_col) begin
         column_count = '0;
         row_count    = next_row();
      end else begin
         column_count = column_count + 1'b1;
         if (column_count == '0) begin
            row_count = next_row();
         end
      end
   endfunction

   always @(posedge clock) begin
      fb_write_type want;
      fb_write_type got;
      if (reset) begin
         sprite                    = '0;
         sprite.image_width        = SIDE_W'(1);
         sprite.image_height       = SIDE_W'(1);
         sprite.transparent_colour = '1;
         column_count              = '0;
         row_count                 = '0;
         expected_writes.delete();
      end else begin
         // the stimulus must keep register writes to while the block is idle; the checker does not enforce it
         if (csr_write_enable) begin
            case (csr_index)
               REG_POS_X:        sprite.pos_x              = csr_write_data[POS_W-1:0];
               REG_POS_Y:        sprite.pos_y              = csr_write_data[POS_W-1:0];
               REG_HOT_X:        sprite.hot_x              = csr_write_data[HOT_W-1:0];
               REG_HOT_Y:        sprite.hot_y              = csr_write_data[HOT_W-1:0];
               REG_IMAGE_WIDTH:  sprite.image_width        = csr_write_data[SIDE_W-1:0];
               REG_IMAGE_HEIGHT: sprite.image_height       = csr_write_data[SIDE_W-1:0];
               REG_TRANSPARENT:  sprite.transparent_colour = csr_write_data[KEY_W-1:0];
               default: ;
            endcase
         end

         // pixel beat: maybe one write, counters always advance
         if (req_valid && req_ready) begin
            if (predict_pixel_write(req_src_colour, want)) begin
               expected_writes.push_back(want);
            end
            step_raster();
         end

         // result beat against the oldest expected write
         if (rsp_valid && rsp_ready) begin
            got.address = rsp_write_address;
            got.colour  = rsp_pixel_colour;
            if (expected_writes.size() == 0) begin
               if (errors < 10) begin
                  $display("unexpected write: address %0d colour %0d",
                           got.address, got.colour);
               end
               errors++;
            end else begin
               want = expected_writes.pop_front();
               if (got.address !== want.address || got.colour !== want.colour) begin
                  if (errors < 10) begin
                     $display("write mismatch: address exp %0d got %0d, colour exp %0d got %0d",
                              want.address, got.address, want.colour, got.colour);
                  end
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_writes <= expected_writes.size();
   end

endmodule

>>> tb/clipped_colour_key_blit_tb.sv
// Testbench top for the colour-key sprite blitter: clock, reset, register set-up,
// pixel stream with random gaps and result back-pressure, watchdog and verdict.
// Depends on ckb_pkg, clipped_colour_key_blit and ckb_blit_checker.
module clipped_colour_key_blit_tb;
   import ckb_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;  // not decoded by the block

   localparam int RANDOM_ITEMS    = 1900;
   localparam int PRESSURE_ITEMS  = 200;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_GAP         = 17;
   localparam int SETTLE_CYCLES   = 4;    // two-stage pipeline plus margin
   // worst legal quiet stretch is the hold-off plus a couple of gaps
   localparam int STALL_LIMIT     = 4000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [COLOUR_W-1:0]    req_src_colour;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [ADDR_W-1:0]      rsp_write_address;
   logic [COLOUR_W-1:0]    rsp_pixel_colour;
   int                     mismatch_count;
   int                     pending_writes;

   int   send_mode        = 0;
   int   recv_mode        = 0;
   int   colour_key_now   = -1;
   logic hold_off_request = 1'b0;
   int   stall_cycles     = 0;

   always #5 clock = ~clock;

   clipped_colour_key_blit u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_src_colour    (req_src_colour),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_colour  (rsp_pixel_colour)
   );

   ckb_blit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_src_colour    (req_src_colour),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_colour  (rsp_pixel_colour),
      .mismatch_count    (mismatch_count),
      .pending_writes    (pending_writes)
   );

   // Gap modes: 0 back to back, 1 every beat random, 2 occasional gaps
   function automatic int draw_gap(input int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, MAX_GAP);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      endcase
   endfunction

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // value in the low bits, random junk above the register width
   function automatic logic [CSR_DATA_W-1:0] pad_field(input int value, input int width);
      logic [CSR_DATA_W-1:0] upper;
      upper = {CSR_DATA_W{1'b1}} << width;
      return (CSR_DATA_W'($urandom) & upper) | (CSR_DATA_W'(value) & ~upper);
   endfunction

   // pixels hit the transparent colour now and then so the key gets exercised
   function automatic logic [COLOUR_W-1:0] pick_colour();
      if (colour_key_now >= 0 && colour_key_now <= 255 && $urandom_range(0, 3) == 0) begin
         return COLOUR_W'(colour_key_now);
      end
      return COLOUR_W'($urandom);
   endfunction

   // leaves the write enable high so writes can follow back to back
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic program_sprite(input int px, input int py, input int hx, input int hy,
                                 input int w, input int h, input int key);
      write_register(REG_POS_X,        pad_field(px, POS_W));
      write_register(REG_POS_Y,        pad_field(py, POS_W));
      write_register(REG_HOT_X,        pad_field(hx, HOT_W));
      write_register(REG_HOT_Y,        pad_field(hy, HOT_W));
      write_register(REG_IMAGE_WIDTH,  pad_field(w, SIDE_W));
      write_register(REG_IMAGE_HEIGHT, pad_field(h, SIDE_W));
      write_register(REG_TRANSPARENT,  pad_field(key, KEY_W));
      csr_write_enable <= 1'b0;
      colour_key_now = key;
   endtask

   task automatic send_pixel(input logic [COLOUR_W-1:0] colour);
      int gap;
      gap = draw_gap(send_mode);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_src_colour <= colour;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // drop valid, drain the results, then let off-screen pixels clear the pipe
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random ready gaps, one long hold-off on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         gap = draw_gap(recv_mode);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Watchdog on cycles without any accepted beat or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("clipped_colour_key_blit test failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int streamed;
      int count;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_src_colour   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset set-up: 1x1 sprite at the origin, no key, colour extremes
      send_pixel(8'h00);
      send_pixel(8'hFF);
      settle();

      // 3x2 over the bottom-right corner: keyed pixel on screen, last address,
      // right-edge clip and wrap
      program_sprite(318, 238, 0, 0, 3, 2, 5);
      send_pixel(8'd5);
      send_pixel(8'd7);
      send_pixel(8'd9);
      send_pixel(8'd11);
      send_pixel(8'd13);
      send_pixel(8'd5);
      settle();

      // hot spot pulls the sprite off the top-left, key at the top colour
      program_sprite(1, 0, 2, 1, 4, 2, 255);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd128);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd255);
      send_pixel(8'd3);
      settle();

      // register extremes: zero width and oversize height act as 256,
      // negative key other than -1, undecoded register index
      write_register(REG_SPARE, CSR_DATA_W'($urandom));
      program_sprite(1023, -1024, 255, 255, 0, 511, -2);
      repeat (3) send_pixel(pick_colour());
      settle();

      // opposite corner, width just over the limit, key of 256 (stored as -256 in the signed key field)
      program_sprite(-1024, 1023, 0, 0, 257, 1, 256);
      repeat (2) send_pixel(pick_colour());
      settle();

      // whole sprite on screen, no key: receiver holds off so the block backs up
      program_sprite(100, 60, 0, 0, 16, 16, -1);
      send_mode        = 0;
      recv_mode        = 0;
      hold_off_request = 1'b1;
      repeat (PRESSURE_ITEMS) send_pixel(pick_colour());
      settle();
      streamed = PRESSURE_ITEMS;

      // random placements, sizes, keys and gap patterns
      while (streamed < RANDOM_ITEMS) begin
         int px;
         int py;
         int w;
         int h;
         int key;
         case ($urandom_range(0, 5))
            0:       px = span(-1024, 1023);
            1:       px = span(-40, 40);
            2:       px = span(280, 359);
            default: px = span(-20, 340);
         endcase
         case ($urandom_range(0, 5))
            0:       py = span(-1024, 1023);
            1:       py = span(-40, 40);
            2:       py = span(200, 279);
            default: py = span(-20, 260);
         endcase
         case ($urandom_range(0, 7))
            0:       w = 256;
            1:       w = span(0, 511);
            2:       w = 1;
            default: w = span(1, 24);
         endcase
         case ($urandom_range(0, 7))
            0:       h = 256;
            1:       h = span(0, 511);
            2:       h = 1;
            default: h = span(1, 24);
         endcase
         case ($urandom_range(0, 4))
            0:       key = -1;
            1:       key = span(-256, 255);
            default: key = span(0, 255);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            write_register(REG_SPARE, CSR_DATA_W'($urandom));
         end
         program_sprite(px, py,
                        ($urandom_range(0, 3) == 0) ? span(0, 255) : span(0, 15),
                        ($urandom_range(0, 3) == 0) ? span(0, 255) : span(0, 15),
                        w, h, key);
         send_mode = $urandom_range(0, 2);
         recv_mode = $urandom_range(0, 2);
         count     = $urandom_range(60, 200);
         repeat (count) send_pixel(pick_colour());
         settle();
         streamed += count;
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_writes == 0) begin
         $display("clipped_colour_key_blit test passed");
      end else begin
         $display("clipped_colour_key_blit test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ckb_pkg.sv
src/ckb_config.sv
src/ckb_position.sv
src/ckb_clip.sv
src/clipped_colour_key_blit.sv
tb/ckb_blit_checker.sv
tb/clipped_colour_key_blit_tb.sv
